[src/eci_pkg.sv]
package eci_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] ONE_FIX = 32'(1) << FRAC_BITS;
  localparam logic [31:0] TWO_FIX = 32'(2) << FRAC_BITS;
  localparam logic [31:0] X_RND   = 32'(1) << (FRAC_BITS - 1);

  // quarter-wave sine polynomial, Q30
  localparam logic [30:0] SIN_A   = 31'd1686629713;
  localparam logic [29:0] SIN_B   = 30'd693598671;
  localparam logic [26:0] SIN_C   = 27'd80710782;
  localparam int          SIN_SH  = 30 - FRAC_BITS;
  localparam logic [30:0] SIN_RND = 31'(1) << (29 - FRAC_BITS);
  localparam int          M_W     = FRAC_BITS + 1;

  localparam logic [15:0] QTR_TURN = 16'h4000;

  // phase divider
  localparam int PH_NUMW = 17;
  localparam int PH_DENW = 13;
  localparam int PH_SH   = 17;
  localparam int PH_DW   = 35;
  localparam int PH_VW   = PH_DENW + 1;
  localparam int PH_QW   = 22;

  // scaling divider
  localparam int SC_QW = 32;

  localparam logic [3:0] OP_LINEAR   = 4'd0;
  localparam logic [3:0] OP_IN2      = 4'd1;
  localparam logic [3:0] OP_IN3      = 4'd2;
  localparam logic [3:0] OP_IN4      = 4'd3;
  localparam logic [3:0] OP_OUT2     = 4'd4;
  localparam logic [3:0] OP_OUT3     = 4'd5;
  localparam logic [3:0] OP_OUT4     = 4'd6;
  localparam logic [3:0] OP_BNC_COS  = 4'd7;
  localparam logic [3:0] OP_BNC_SQ   = 4'd8;
  localparam logic [3:0] OP_RSVD     = 4'd9;
  localparam logic [3:0] OP_BNC_ABS  = 4'd10;
  localparam logic [3:0] OP_HALF_COS = 4'd11;
  localparam logic [3:0] OP_QTR_SIN  = 4'd12;
  localparam logic [3:0] OP_QTR_COS  = 4'd13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_ZERO_N = 2'd2;

  typedef enum logic [2:0] {
    CL_POLY,
    CL_OUT,
    CL_BOUNCE,
    CL_HALF,
    CL_QSIN,
    CL_QCOS
  } cls_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] base;
    logic               sub;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    cls_t               cls;
    logic signed [32:0] delta;
    logic [31:0]        un;
    logic [31:0]        den;
    logic               use_cos;
    logic               use_abs;
  } job_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [31:0] ux;
    logic [31:0] un;
    logic [31:0] den;
    logic        neg;
  } sc_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [32:0] qmag;
    logic        neg;
  } res_t;

endpackage

[src/easing_curve_interpolator_top.sv]
// Easing curve interpolator.
// Input stream: one word per item. in_tuser[3:0] picks the curve; in_tdata
// carries start and end value (signed Q16.16), step index and step count.
// Output stream: one word per item, in order. out_tdata is the curve value,
// out_tuser the status (ok, unsupported curve, zero step count); on an error
// the value is zero.
// Throughput: one item per cycle. Every item takes the same path: four front
// stages, a 22-stage phase divider, an 8-stage sine unit, a product stage, a
// 32-stage divider with rounding and the output register.
// When the receiver holds out_tready low with a word waiting, the whole
// pipeline freezes and in_tready drops; nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) clears all valid bits; items in flight
// are discarded.
module easing_curve_interpolator_top import eci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] start_value, [63:32] end_value, [71:64] step_index, [79:72] step_count
  input  logic [79:0] in_tdata,
  // [3:0] op
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] curve_value
  output logic [31:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  logic en;

  logic             fr_v;
  job_t             fr_job;
  logic [PH_DW-1:0] fr_dend;
  logic [PH_VW-1:0] fr_dv;

  logic        ph_v;
  job_t        ph_job;
  logic [15:0] ph_phase;

  logic tr_v;
  sc_t  tr_sc;

  logic dv_v;
  res_t dv_res;

  logic        out_valid_r;
  logic [31:0] out_value_r, value_nxt;
  logic [1:0]  out_status_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  eci_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (in_tvalid),
    .op          (in_tuser),
    .start_value (in_tdata[31:0]),
    .end_value   (in_tdata[63:32]),
    .step_index  (in_tdata[71:64]),
    .step_count  (in_tdata[79:72]),
    .out_v       (fr_v),
    .out_job     (fr_job),
    .out_dend    (fr_dend),
    .out_dv      (fr_dv)
  );

  eci_phdiv u_phdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (fr_v),
    .in_job    (fr_job),
    .in_dend   (fr_dend),
    .in_dv     (fr_dv),
    .out_v     (ph_v),
    .out_job   (ph_job),
    .out_phase (ph_phase)
  );

  eci_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (ph_v),
    .in_job   (ph_job),
    .in_phase (ph_phase),
    .out_v    (tr_v),
    .out_sc   (tr_sc)
  );

  eci_scdiv u_scdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (tr_v),
    .in_sc   (tr_sc),
    .out_v   (dv_v),
    .out_res (dv_res)
  );

  // apply sign, add to base, saturate; zero on an error status
  logic signed [34:0] mag_s, sum_s;

  always_comb begin
    mag_s = signed'({2'b00, dv_res.qmag});
    if (dv_res.neg ^ dv_res.ctx.sub) mag_s = -mag_s;
    sum_s = 35'($signed(dv_res.ctx.base)) + mag_s;
    priority if (dv_res.ctx.status != ST_OK) value_nxt = '0;
    else if (sum_s > SAT_HI)                 value_nxt = 32'h7FFF_FFFF;
    else if (sum_s < SAT_LO)                 value_nxt = 32'h8000_0000;
    else                                     value_nxt = sum_s[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r  <= value_nxt;
      out_status_r <= dv_res.ctx.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0)
    else $error("error word carries a nonzero value");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_BAD_OP || out_tuser == ST_ZERO_N))
    else $error("illegal status code");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is frozen");

endmodule

[src/eci_front.sv]
module eci_front import eci_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [3:0]          op,
  input  logic signed [31:0]  start_value,
  input  logic signed [31:0]  end_value,
  input  logic [7:0]          step_index,
  input  logic [7:0]          step_count,
  output logic                out_v,
  output job_t                out_job,
  output logic [PH_DW-1:0]    out_dend,
  output logic [PH_VW-1:0]    out_dv
);

  // stage 1: saturate step, status, delta
  logic               v1_r;
  logic [3:0]         op1_r;
  logic [1:0]         st1_r;
  logic signed [31:0] start1_r, end1_r;
  logic [7:0]         s1_r, n1_r;
  logic signed [32:0] d1_r;
  logic [1:0]         st1_nxt;

  always_comb begin
    priority if (op == OP_RSVD || op > OP_QTR_COS) st1_nxt = ST_BAD_OP;
    else if (step_count == 8'd0)                 st1_nxt = ST_ZERO_N;
    else                                         st1_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= op;
      st1_r    <= st1_nxt;
      start1_r <= start_value;
      end1_r   <= end_value;
      s1_r     <= (step_index > step_count) ? step_count : step_index;
      n1_r     <= step_count;
      d1_r     <= 33'(end_value) - 33'(start_value);
    end
  end

  // stage 2: classify, squares
  logic               v2_r;
  logic [3:0]         op2_r;
  cls_t               cls2_r, cls2_nxt;
  logic               cos2_r, cos2_nxt, abs2_r, abs2_nxt;
  ctx_t               ctx2_r, ctx2_nxt;
  logic signed [32:0] d2_r;
  logic [7:0]         s2_r, n2_r, r2_r;
  logic [15:0]        ss2_r, nn2_r, rr2_r;
  logic [7:0]         r1;

  assign r1 = n1_r - s1_r;

  always_comb begin
    cls2_nxt = CL_POLY;
    cos2_nxt = 1'b1;
    abs2_nxt = 1'b0;
    unique case (op1_r)
      OP_LINEAR, OP_IN2, OP_IN3, OP_IN4: cls2_nxt = CL_POLY;
      OP_OUT2, OP_OUT3, OP_OUT4:         cls2_nxt = CL_OUT;
      OP_BNC_COS, OP_BNC_SQ:             cls2_nxt = CL_BOUNCE;
      OP_BNC_ABS: begin
        cls2_nxt = CL_BOUNCE;
        abs2_nxt = 1'b1;
      end
      OP_HALF_COS: cls2_nxt = CL_HALF;
      OP_QTR_SIN: begin
        cls2_nxt = CL_QSIN;
        cos2_nxt = 1'b0;
      end
      OP_QTR_COS: cls2_nxt = CL_QCOS;
      default:    cls2_nxt = CL_POLY;
    endcase
    ctx2_nxt.status = st1_r;
    ctx2_nxt.sub    = (cls2_nxt == CL_OUT) || (cls2_nxt == CL_BOUNCE);
    ctx2_nxt.base   = ctx2_nxt.sub ? end1_r : start1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      cls2_r <= cls2_nxt;
      cos2_r <= cos2_nxt;
      abs2_r <= abs2_nxt;
      ctx2_r <= ctx2_nxt;
      d2_r   <= d1_r;
      s2_r   <= s1_r;
      n2_r   <= n1_r;
      r2_r   <= r1;
      ss2_r  <= 16'(s1_r) * 16'(s1_r);
      nn2_r  <= 16'(n1_r) * 16'(n1_r);
      rr2_r  <= 16'(r1) * 16'(r1);
    end
  end

  // stage 3: cubes, phase fraction
  logic               v3_r;
  logic [3:0]         op3_r;
  cls_t               cls3_r;
  logic               cos3_r, abs3_r;
  ctx_t               ctx3_r;
  logic signed [32:0] d3_r;
  logic [7:0]         s3_r, n3_r;
  logic [15:0]        ss3_r, nn3_r, rr3_r;
  logic [23:0]        sss3_r, nnn3_r, rrr3_r;
  logic [PH_NUMW-1:0] pnum3_r, pnum_nxt;
  logic [PH_DENW-1:0] pden3_r, pden_nxt;

  always_comb begin
    pnum_nxt = '0;
    pden_nxt = PH_DENW'(1);
    if (ctx2_r.status == ST_OK) begin
      unique case (op2_r)
        OP_BNC_COS: begin
          pnum_nxt = PH_NUMW'(s2_r) << 1;
          pden_nxt = PH_DENW'(n2_r);
        end
        OP_BNC_SQ: begin
          pnum_nxt = PH_NUMW'(ss2_r) << 1;
          pden_nxt = PH_DENW'(n2_r) * PH_DENW'(15);
        end
        OP_BNC_ABS: begin
          pnum_nxt = PH_NUMW'(ss2_r);
          pden_nxt = PH_DENW'(n2_r) * PH_DENW'(20);
        end
        OP_HALF_COS: begin
          pnum_nxt = PH_NUMW'(s2_r);
          pden_nxt = PH_DENW'(n2_r) << 1;
        end
        OP_QTR_SIN, OP_QTR_COS: begin
          pnum_nxt = PH_NUMW'(s2_r);
          pden_nxt = PH_DENW'(n2_r) << 2;
        end
        default: begin
          pnum_nxt = '0;
          pden_nxt = PH_DENW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r   <= op2_r;
      cls3_r  <= cls2_r;
      cos3_r  <= cos2_r;
      abs3_r  <= abs2_r;
      ctx3_r  <= ctx2_r;
      d3_r    <= d2_r;
      s3_r    <= s2_r;
      n3_r    <= n2_r;
      ss3_r   <= ss2_r;
      nn3_r   <= nn2_r;
      rr3_r   <= rr2_r;
      sss3_r  <= 24'(ss2_r) * 24'(s2_r);
      nnn3_r  <= 24'(nn2_r) * 24'(n2_r);
      rrr3_r  <= 24'(rr2_r) * 24'(r2_r);
      pnum3_r <= pnum_nxt;
      pden3_r <= pden_nxt;
    end
  end

  // stage 4: fourth powers, pick numerator and denominator
  logic        v4_r;
  job_t        job4_r, job_nxt;
  logic [PH_DW-1:0] dend4_r;
  logic [PH_VW-1:0] dv4_r;
  logic [31:0] ss4, nn4, rr4;

  assign ss4 = 32'(ss3_r) * 32'(ss3_r);
  assign nn4 = 32'(nn3_r) * 32'(nn3_r);
  assign rr4 = 32'(rr3_r) * 32'(rr3_r);

  always_comb begin
    job_nxt.ctx     = ctx3_r;
    job_nxt.cls     = cls3_r;
    job_nxt.delta   = d3_r;
    job_nxt.use_cos = cos3_r;
    job_nxt.use_abs = abs3_r;
    unique case (op3_r)
      OP_LINEAR: begin
        job_nxt.un  = 32'(s3_r);
        job_nxt.den = 32'(n3_r);
      end
      OP_IN2: begin
        job_nxt.un  = 32'(ss3_r);
        job_nxt.den = 32'(nn3_r);
      end
      OP_IN3: begin
        job_nxt.un  = 32'(sss3_r);
        job_nxt.den = 32'(nnn3_r);
      end
      OP_IN4: begin
        job_nxt.un  = ss4;
        job_nxt.den = nn4;
      end
      OP_OUT3: begin
        job_nxt.un  = 32'(rrr3_r);
        job_nxt.den = 32'(nnn3_r);
      end
      OP_OUT4: begin
        job_nxt.un  = rr4;
        job_nxt.den = nn4;
      end
      OP_OUT2, OP_BNC_COS, OP_BNC_SQ, OP_BNC_ABS: begin
        job_nxt.un  = 32'(rr3_r);
        job_nxt.den = 32'(nn3_r);
      end
      OP_HALF_COS: begin
        job_nxt.un  = '0;
        job_nxt.den = TWO_FIX;
      end
      OP_QTR_SIN, OP_QTR_COS: begin
        job_nxt.un  = '0;
        job_nxt.den = ONE_FIX;
      end
      default: begin
        job_nxt.un  = '0;
        job_nxt.den = 32'd1;
      end
    endcase
    if (ctx3_r.status != ST_OK) begin
      job_nxt.un  = '0;
      job_nxt.den = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job4_r  <= job_nxt;
      dend4_r <= (PH_DW'(pnum3_r) << PH_SH) + PH_DW'(pden3_r);
      dv4_r   <= {pden3_r, 1'b0};
    end
  end

  assign out_v    = v4_r;
  assign out_job  = job4_r;
  assign out_dend = dend4_r;
  assign out_dv   = dv4_r;

endmodule

[src/eci_phdiv.sv]
module eci_phdiv import eci_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  job_t             in_job,
  input  logic [PH_DW-1:0] in_dend,
  input  logic [PH_VW-1:0] in_dv,
  output logic             out_v,
  output job_t             out_job,
  output logic [15:0]      out_phase
);

  // restoring divider, one quotient bit per stage; only the low 16 bits are kept
  logic             v_r    [PH_QW];
  job_t             job_r  [PH_QW];
  logic [PH_DW-1:0] dend_r [PH_QW];
  logic [PH_VW-1:0] dv_r   [PH_QW];
  logic [PH_VW-1:0] rem_r  [PH_QW];
  logic [15:0]      q_r    [PH_QW];

  for (genvar g = 0; g < PH_QW; g++) begin : g_stage
    logic             pv;
    job_t             pjob;
    logic [PH_DW-1:0] pdend;
    logic [PH_VW-1:0] pdv, prem;
    logic [15:0]      pq;
    logic [PH_VW:0]   trial;
    logic             take;

    if (g == 0) begin : g_first
      assign pv    = in_v;
      assign pjob  = in_job;
      assign pdend = in_dend;
      assign pdv   = in_dv;
      assign prem  = PH_VW'(in_dend[PH_DW-1:PH_QW]);
      assign pq    = '0;
    end else begin : g_next
      assign pv    = v_r[g-1];
      assign pjob  = job_r[g-1];
      assign pdend = dend_r[g-1];
      assign pdv   = dv_r[g-1];
      assign prem  = rem_r[g-1];
      assign pq    = q_r[g-1];
    end

    assign trial = {prem, pdend[PH_QW-1-g]};
    assign take  = trial >= {1'b0, pdv};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g] <= 1'b0;
      else if (en) v_r[g] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        job_r[g]  <= pjob;
        dend_r[g] <= pdend;
        dv_r[g]   <= pdv;
        rem_r[g]  <= take ? PH_VW'(trial - {1'b0, pdv}) : PH_VW'(trial);
        q_r[g]    <= {pq[14:0], take};
      end
    end
  end

  assign out_v     = v_r[PH_QW-1];
  assign out_job   = job_r[PH_QW-1];
  assign out_phase = q_r[PH_QW-1];

endmodule

[src/eci_trig.sv]
module eci_trig import eci_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  job_t        in_job,
  input  logic [15:0] in_phase,
  output logic        out_v,
  output sc_t         out_sc
);

  localparam int PW = 32 + M_W;

  // T0: fold phase onto the first quadrant
  logic        v0_r, neg0_r;
  job_t        job0_r;
  logic [30:0] z0_r;
  logic [15:0] p0;
  logic [14:0] x0;

  always_comb begin
    p0 = in_phase + (in_job.use_cos ? QTR_TURN : 16'd0);
    x0 = {1'b0, p0[13:0]};
    if (p0[14]) x0 = 15'(QTR_TURN) - x0;
  end

  // T1..T4: polynomial, one multiply per stage
  logic        v1_r, neg1_r, v2_r, neg2_r, v3_r, neg3_r, v4_r, neg4_r;
  job_t        job1_r, job2_r, job3_r, job4_r;
  logic [30:0] z1_r, z2_r, z3_r;
  logic [30:0] zz1_r, zz2_r;
  logic [29:0] inner2_r;
  logic [30:0] poly3_r;
  logic [30:0] qs4_r;
  logic [61:0] t1, t4;
  logic [57:0] t2;
  logic [60:0] t3;

  assign t1 = 62'(z0_r) * 62'(z0_r);
  assign t2 = 58'(zz1_r) * 58'(SIN_C);
  assign t3 = 61'(zz2_r) * 61'(inner2_r);
  assign t4 = 62'(z3_r) * 62'(poly3_r);

  // T5: round to fixed point, build the scale numerator
  logic           v5_r, wneg5_r, dneg5_r;
  job_t           job5_r, job5_nxt;
  logic [M_W-1:0] m5_r, m_nxt;
  logic [31:0]    dmag5_r;
  logic [31:0]    msum;
  logic           wneg_nxt;

  always_comb begin
    msum     = {1'b0, qs4_r} + {1'b0, SIN_RND};
    m_nxt    = M_W'(msum >> SIN_SH);
    wneg_nxt = neg4_r && !job4_r.use_abs;
    job5_nxt = job4_r;
    unique case (job4_r.cls)
      CL_HALF, CL_QCOS: job5_nxt.un = wneg_nxt ? ONE_FIX + 32'(m_nxt) : ONE_FIX - 32'(m_nxt);
      CL_QSIN:          job5_nxt.un = 32'(m_nxt);
      default: ;
    endcase
  end

  // T6: delta times w for the bounce curves
  logic          v6_r, wneg6_r, dneg6_r;
  job_t          job6_r;
  logic [31:0]   dmag6_r;
  logic [PW-1:0] prod6_r;

  // T7: round and hand over
  logic        v7_r;
  sc_t         sc7_r, sc_nxt;
  logic [PW-1:0] xsum;

  always_comb begin
    xsum       = prod6_r + PW'(X_RND);
    sc_nxt.ctx = job6_r.ctx;
    sc_nxt.un  = job6_r.un;
    sc_nxt.den = job6_r.den;
    if (job6_r.cls == CL_BOUNCE) begin
      sc_nxt.ux  = 32'(xsum >> FRAC_BITS);
      sc_nxt.neg = dneg6_r ^ wneg6_r;
    end else begin
      sc_nxt.ux  = dmag6_r;
      sc_nxt.neg = dneg6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job0_r   <= in_job;
      neg0_r   <= p0[15];
      z0_r     <= {x0, 16'd0};

      job1_r   <= job0_r;
      neg1_r   <= neg0_r;
      z1_r     <= z0_r;
      zz1_r    <= t1[60:30];

      job2_r   <= job1_r;
      neg2_r   <= neg1_r;
      z2_r     <= z1_r;
      zz2_r    <= zz1_r;
      inner2_r <= SIN_B - 30'(t2[57:30]);

      job3_r   <= job2_r;
      neg3_r   <= neg2_r;
      z3_r     <= z2_r;
      poly3_r  <= SIN_A - 31'(t3[60:30]);

      job4_r   <= job3_r;
      neg4_r   <= neg3_r;
      qs4_r    <= t4[60:30];

      job5_r   <= job5_nxt;
      m5_r     <= m_nxt;
      wneg5_r  <= wneg_nxt;
      dneg5_r  <= job4_r.delta[32];
      dmag5_r  <= job4_r.delta[32] ? 32'(-job4_r.delta) : 32'(job4_r.delta);

      job6_r   <= job5_r;
      wneg6_r  <= wneg5_r;
      dneg6_r  <= dneg5_r;
      dmag6_r  <= dmag5_r;
      prod6_r  <= PW'(dmag5_r) * PW'(m5_r);

      sc7_r    <= sc_nxt;
    end
  end

  assign out_v  = v7_r;
  assign out_sc = sc7_r;

endmodule

[src/eci_scdiv.sv]
module eci_scdiv import eci_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  sc_t  in_sc,
  output logic out_v,
  output res_t out_res
);

  // product stage
  logic        vp_r;
  ctx_t        ctxp_r;
  logic        negp_r;
  logic [31:0] denp_r;
  logic [63:0] prodp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else if (en) vp_r <= in_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxp_r  <= in_sc.ctx;
      negp_r  <= in_sc.neg;
      denp_r  <= in_sc.den;
      prodp_r <= 64'(in_sc.ux) * 64'(in_sc.un);
    end
  end

  // restoring divider; the quotient never exceeds the multiplicand, so it fits 32 bits
  logic        v_r    [SC_QW];
  ctx_t        ctx_r  [SC_QW];
  logic        neg_r  [SC_QW];
  logic [31:0] den_r  [SC_QW];
  logic [31:0] lo_r   [SC_QW];
  logic [31:0] rem_r  [SC_QW];
  logic [31:0] q_r    [SC_QW];

  for (genvar g = 0; g < SC_QW; g++) begin : g_stage
    logic        pv, pneg;
    ctx_t        pctx;
    logic [31:0] pden, plo, prem, pq;
    logic [32:0] trial;
    logic        take;

    if (g == 0) begin : g_first
      assign pv   = vp_r;
      assign pctx = ctxp_r;
      assign pneg = negp_r;
      assign pden = denp_r;
      assign plo  = prodp_r[31:0];
      assign prem = prodp_r[63:32];
      assign pq   = '0;
    end else begin : g_next
      assign pv   = v_r[g-1];
      assign pctx = ctx_r[g-1];
      assign pneg = neg_r[g-1];
      assign pden = den_r[g-1];
      assign plo  = lo_r[g-1];
      assign prem = rem_r[g-1];
      assign pq   = q_r[g-1];
    end

    assign trial = {prem, plo[SC_QW-1-g]};
    assign take  = trial >= {1'b0, pden};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g] <= 1'b0;
      else if (en) v_r[g] <= pv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[g] <= pctx;
        neg_r[g] <= pneg;
        den_r[g] <= pden;
        lo_r[g]  <= plo;
        rem_r[g] <= take ? 32'(trial - {1'b0, pden}) : 32'(trial);
        q_r[g]   <= {pq[30:0], take};
      end
    end
  end

  // round half away from zero on the magnitude
  logic vr_r;
  res_t res_r, res_nxt;
  logic round_up;

  always_comb begin
    round_up     = {rem_r[SC_QW-1], 1'b0} >= {1'b0, den_r[SC_QW-1]};
    res_nxt.ctx  = ctx_r[SC_QW-1];
    res_nxt.neg  = neg_r[SC_QW-1];
    res_nxt.qmag = 33'(q_r[SC_QW-1]) + 33'(round_up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vr_r <= 1'b0;
    else if (en) vr_r <= v_r[SC_QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_v   = vr_r;
  assign out_res = res_r;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import eci_pkg::*;

  localparam int LATENCY = 69;
  localparam int WD_LIMIT = 4000;
  localparam int N_RANDOM = 1230;

  // quarter-wave sine constants, Q30
  localparam longint unsigned PA = 64'd1686629713;
  localparam longint unsigned PB = 64'd693598671;
  localparam longint unsigned PC = 64'd80710782;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } curve_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  int errors = 0;
  bit send_done = 1'b0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  easing_curve_interpolator_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // x*num/den, nearest, ties away from zero
  function automatic longint scale_round(longint x, longint num, longint unsigned den);
    bit neg;
    longint unsigned ux, un, a, q1, r1, b, q2, r2, q;
    neg = (x < 0) != (num < 0);
    ux = x < 0 ? -x : x;
    un = num < 0 ? -num : num;
    if (den == 0) return 0;
    a = (ux >> 16) * un;
    q1 = a / den;
    r1 = a % den;
    b = (r1 << 16) + (ux & 64'hFFFF) * un;
    q2 = b / den;
    r2 = b % den;
    q = (q1 << 16) + q2;
    if (2 * r2 >= den) q++;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] turn_frac(longint unsigned num, longint unsigned den);
    return 16'(((num << 17) + den) / (2 * den));
  endfunction

  function automatic longint sine_q(logic [15:0] p);
    logic [1:0] quad;
    longint unsigned x, z, z2, inner, poly, m;
    quad = p[15:14];
    x = p[13:0];
    if (quad[0]) x = 16384 - x;
    z = x << 16;
    z2 = (z * z) >> 30;
    inner = PB - ((z2 * PC) >> 30);
    poly = PA - ((z2 * inner) >> 30);
    m = (((z * poly) >> 30) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint cosine_q(logic [15:0] p);
    return sine_q(p + QTR_TURN);
  endfunction

  function automatic curve_res_t predict_curve(logic [3:0] op, logic [31:0] sv,
                                               logic [31:0] ev, logic [7:0] si,
                                               logic [7:0] sc);
    curve_res_t res;
    longint st, en, delta, val, w, one, p;
    longint unsigned s, n, r;
    one = longint'(1) << FRAC_BITS;
    st = longint'(signed'(sv));
    en = longint'(signed'(ev));
    s = si;
    n = sc;
    val = 0;
    res.status = ST_OK;
    if (op == OP_RSVD || op > OP_QTR_COS) res.status = ST_BAD_OP;
    else if (n == 0) res.status = ST_ZERO_N;
    else begin
      delta = en - st;
      if (s > n) s = n;
      r = n - s;
      case (op)
        OP_LINEAR: val = st + scale_round(delta, s, n);
        OP_IN2, OP_IN3, OP_IN4: begin
          p = op + 1;
          val = st + scale_round(delta, s ** p, n ** p);
        end
        OP_OUT2, OP_OUT3, OP_OUT4: begin
          p = op - 2;
          val = en - scale_round(delta, r ** p, n ** p);
        end
        OP_BNC_COS, OP_BNC_SQ, OP_BNC_ABS: begin
          if (op == OP_BNC_COS) w = cosine_q(turn_frac(2 * s, n));
          else if (op == OP_BNC_SQ) w = cosine_q(turn_frac(2 * s * s, 15 * n));
          else begin
            w = cosine_q(turn_frac(s * s, 20 * n));
            if (w < 0) w = -w;
          end
          val = en - scale_round(scale_round(delta, w, one), r * r, n * n);
        end
        OP_HALF_COS: begin
          w = cosine_q(turn_frac(s, 2 * n));
          val = st + scale_round(delta, one - w, 2 * one);
        end
        OP_QTR_SIN: begin
          w = sine_q(turn_frac(s, 4 * n));
          val = st + scale_round(delta, w, one);
        end
        default: begin
          w = cosine_q(turn_frac(s, 4 * n));
          val = st + scale_round(delta, one - w, one);
        end
      endcase
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
    end
    res.value = val[31:0];
    return res;
  endfunction

  class curve_scoreboard;
    curve_res_t pending[$];

    function void note_input(logic [3:0] op, logic [79:0] d);
      pending.push_back(predict_curve(op, d[31:0], d[63:32], d[71:64], d[79:72]));
    endfunction

    task check_result(logic [31:0] value, logic [1:0] status);
      curve_res_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word value=%h status=%0d", value, status));
        return;
      end
      e = pending.pop_front();
      if (value !== e.value)
        report_mismatch($sformatf("curve_value %h, want %h", value, e.value));
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", status, e.status));
    endtask
  endclass

  curve_scoreboard sb = new();

  task automatic send_word(input logic [3:0] op, input logic [31:0] sv,
                           input logic [31:0] ev, input logic [7:0] si,
                           input logic [7:0] sc, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {sc, si, ev, sv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  // input monitor and output checker, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WD_LIMIT);
        $display("easing_curve_interpolator_top verification failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off after start
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    out_tready <= 1'b0;
    wait (hold_off);
    repeat (300) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) begin
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [3:0] op;
    logic [7:0] n, s;
    bit gaps;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    hold_off = 1'b1;
    // directed: extremes, every op, errors, saturation
    for (int k = 0; k < 16; k++)
      send_word(4'(k), 32'h8000_0000, 32'h7FFF_FFFF, 8'd3, 8'd7, 1'b0);
    send_word(OP_LINEAR, 32'h0001_0000, 32'h0005_0000, 8'd10, 8'd0, 1'b0);
    send_word(OP_RSVD, 32'h0001_0000, 32'h0005_0000, 8'd10, 8'd0, 1'b0);
    send_word(OP_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd4, 1'b0);
    send_word(OP_BNC_COS, 32'h7FFF_FFFF, 32'h8000_0000, 8'd1, 8'd255, 1'b0);
    send_word(OP_OUT4, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0, 8'd255, 1'b0);
    send_word(OP_IN4, 32'hFFFF_FFFF, 32'h0000_0000, 8'd255, 8'd255, 1'b0);
    send_word(OP_BNC_ABS, 32'h1234_5678, 32'hFEDC_BA98, 8'd200, 8'd255, 1'b0);
    send_word(OP_QTR_SIN, 32'h0000_0000, 32'h0001_0000, 8'd1, 8'd1, 1'b0);
    send_word(OP_HALF_COS, 32'h0000_0000, 32'h0001_0000, 8'd0, 8'd1, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      gaps = !((i / 100) % 3 == 1);
      op = (i % 10 == 0) ? 4'($urandom()) : 4'($urandom_range(0, 13));
      n = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom());
      s = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, n));
      send_word(op, rand_value(), rand_value(), s, n, gaps);
    end
    in_tvalid <= 1'b0;
    send_done = 1'b1;
  end

  initial begin
    wait (send_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("easing_curve_interpolator_top verification clean");
    end else begin
      $display("easing_curve_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/eci_pkg.sv
src/eci_front.sv
src/eci_phdiv.sv
src/eci_trig.sv
src/eci_scdiv.sv
src/easing_curve_interpolator_top.sv
tb/sv/tb_top.sv
